// File: rtl/core/sorted_array_priority_queue_assert.svh
// Assertion macros shared by the priority queue RTL.
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SAPQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sapq check failed");

// Next-cycle implication, disabled during reset.
`define SAPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sapq check failed");

`endif

// File: rtl/core/sapq_pkg.sv
// Package: sizes, codes and controller/datapath interface types of the priority queue.
`default_nettype none

package sapq_pkg;

   localparam int DEPTH   = 64;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int VALUE_W = 32;
   localparam int PRIO_W  = 16;
   localparam int COUNT_W = 7;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_PULL   = 2'd1,
      OP_PEEK   = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      ERR_OK    = 2'd0,
      ERR_FULL  = 2'd1,
      ERR_EMPTY = 2'd2
   } err_type;

   typedef enum logic [2:0] {
      RD_NONE   = 3'd0,
      RD_BELOW  = 3'd1,
      RD_BELOW2 = 3'd2,
      RD_AT     = 3'd3,
      RD_ABOVE  = 3'd4
   } rd_op_type;

   typedef enum logic [1:0] {
      WR_NONE       = 2'd0,
      WR_SHIFT_BACK = 2'd1,
      WR_SHIFT_FWD  = 2'd2,
      WR_NEW        = 2'd3
   } wr_op_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [PRIO_W-1:0]  prio;
   } slot_type;

   typedef struct packed {
      logic      start;
      logic      pos_load_occ;
      logic      pos_load_one;
      logic      pos_inc;
      logic      pos_dec;
      rd_op_type rd_op;
      wr_op_type wr_op;
      logic      cnt_inc;
      logic      cnt_dec;
      err_type   err_code;
      logic      rsp_load;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic occ_one;
      logic prio_lower;
      logic pos_one;
      logic pos_last;
      logic rsp_free;
   } sts_type;

endpackage

`default_nettype wire

// File: rtl/core/sapq_datapath.sv
// Datapath: slot memory, position and count registers, head copy and result register.
`default_nettype none
`include "sorted_array_priority_queue_assert.svh"

module sapq_datapath
   import sapq_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire cmd_type                   cmd,
   output sts_type                        sts,
   input  wire logic signed [VALUE_W-1:0] req_item_value,
   input  wire logic signed [PRIO_W-1:0]  req_item_priority,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic signed [VALUE_W-1:0]      rsp_head_value,
   output logic [COUNT_W-1:0]             rsp_entry_count,
   output logic [1:0]                     rsp_error_code
);

   slot_type            slot_mem [DEPTH];
   slot_type            rdata_ff;
   slot_type            new_ff;
   slot_type            wdata;
   logic                rd_en;
   logic                wr_en;
   logic [CNT_W-1:0]    raddr_full;
   logic [CNT_W-1:0]    waddr_full;
   logic [IDX_W-1:0]    raddr;
   logic [IDX_W-1:0]    waddr;

   logic [CNT_W-1:0]    pos_ff, pos_in;
   logic [CNT_W-1:0]    occ_ff, occ_in;
   logic [VALUE_W-1:0]  head_ff;
   err_type             err_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_value_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   err_type             rsp_err_ff;

   // Address decode for the single read and single write port
   always_comb begin
      rd_en      = 1'b1;
      raddr_full = pos_ff;
      unique case (cmd.rd_op)
         RD_BELOW:  raddr_full = pos_ff - CNT_W'(1);
         RD_BELOW2: raddr_full = pos_ff - CNT_W'(2);
         RD_AT:     raddr_full = pos_ff;
         RD_ABOVE:  raddr_full = pos_ff + CNT_W'(1);
         default:   rd_en      = 1'b0;
      endcase
   end

   always_comb begin
      wr_en      = 1'b1;
      waddr_full = pos_ff;
      wdata      = rdata_ff;
      unique case (cmd.wr_op)
         WR_SHIFT_BACK: waddr_full = pos_ff;
         WR_SHIFT_FWD:  waddr_full = pos_ff - CNT_W'(1);
         WR_NEW: begin
            waddr_full = pos_ff;
            wdata      = new_ff;
         end
         default:       wr_en      = 1'b0;
      endcase
   end

   assign raddr = raddr_full[IDX_W-1:0];
   assign waddr = waddr_full[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= slot_mem[raddr];
      end
   end

   // Shadow of slot zero, refreshed on every write there
   always_ff @(posedge clock) begin
      if (wr_en && (waddr == '0)) begin
         head_ff <= wdata.value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         new_ff <= '{value: req_item_value, prio: req_item_priority};
         err_ff <= cmd.err_code;
      end
   end

   always_comb begin
      pos_in = pos_ff;
      if (cmd.pos_load_occ) begin
         pos_in = occ_ff;
      end else if (cmd.pos_load_one) begin
         pos_in = CNT_W'(1);
      end else if (cmd.pos_inc) begin
         pos_in = pos_ff + CNT_W'(1);
      end else if (cmd.pos_dec) begin
         pos_in = pos_ff - CNT_W'(1);
      end
   end

   always_comb begin
      occ_in = occ_ff;
      if (cmd.cnt_inc) begin
         occ_in = occ_ff + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         occ_in = occ_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         occ_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         occ_ff <= occ_in;
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_value_ff <= (occ_ff == '0) ? '1 : head_ff;
         rsp_count_ff <= COUNT_W'(occ_ff);
         rsp_err_ff   <= err_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_head_value  = rsp_value_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_error_code  = rsp_err_ff;

   assign sts.full       = (occ_ff == CNT_W'(DEPTH));
   assign sts.empty      = (occ_ff == '0);
   assign sts.occ_one    = (occ_ff == CNT_W'(1));
   assign sts.prio_lower = ($signed(rdata_ff.prio) < $signed(new_ff.prio));
   assign sts.pos_one    = (pos_ff == CNT_W'(1));
   assign sts.pos_last   = ((pos_ff + CNT_W'(1)) >= occ_ff);
   assign sts.rsp_free   = !rsp_valid_ff || !rsp_stall;

   `SAPQ_ASSERT_NOW(a_occ_bound, clock, reset, 1'b1, occ_ff <= CNT_W'(DEPTH))
   `SAPQ_ASSERT_NOW(a_no_overwrite, clock, reset, cmd.rsp_load, !rsp_valid_ff || !rsp_stall)
   `SAPQ_ASSERT_NOW(a_inc_not_full, clock, reset, cmd.cnt_inc, occ_ff != CNT_W'(DEPTH))

endmodule

`default_nettype wire

// File: rtl/core/sapq_ctrl.sv
// Controller: state machine that sequences insert, pull and peek over the datapath.
`default_nettype none
`include "sorted_array_priority_queue_assert.svh"

module sapq_ctrl
   import sapq_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_opcode,
   input  wire sts_type    sts,
   output cmd_type         cmd
);

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_INS_RD  = 7'b0000010,
      S_INS_CMP = 7'b0000100,
      S_INS_PUT = 7'b0001000,
      S_PULL_RD = 7'b0010000,
      S_PULL_MV = 7'b0100000,
      S_DONE    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               case (req_opcode)
                  OP_INSERT: begin
                     if (sts.full) begin
                        cmd.err_code = ERR_FULL;
                        state_in     = S_DONE;
                     end else begin
                        cmd.pos_load_occ = 1'b1;
                        state_in         = sts.empty ? S_INS_PUT : S_INS_RD;
                     end
                  end
                  OP_PULL: begin
                     if (sts.empty) begin
                        cmd.err_code = ERR_EMPTY;
                        state_in     = S_DONE;
                     end else if (sts.occ_one) begin
                        cmd.cnt_dec = 1'b1;
                        state_in    = S_DONE;
                     end else begin
                        cmd.pos_load_one = 1'b1;
                        state_in         = S_PULL_RD;
                     end
                  end
                  default: begin
                     cmd.err_code = sts.empty ? ERR_EMPTY : ERR_OK;
                     state_in     = S_DONE;
                  end
               endcase
            end
         end
         S_INS_RD: begin
            cmd.rd_op = RD_BELOW;
            state_in  = S_INS_CMP;
         end
         S_INS_CMP: begin
            if (sts.prio_lower) begin
               cmd.wr_op   = WR_SHIFT_BACK;
               cmd.pos_dec = 1'b1;
               if (sts.pos_one) begin
                  state_in = S_INS_PUT;
               end else begin
                  cmd.rd_op = RD_BELOW2;
               end
            end else begin
               cmd.wr_op   = WR_NEW;
               cmd.cnt_inc = 1'b1;
               state_in    = S_DONE;
            end
         end
         S_INS_PUT: begin
            cmd.wr_op   = WR_NEW;
            cmd.cnt_inc = 1'b1;
            state_in    = S_DONE;
         end
         S_PULL_RD: begin
            cmd.rd_op = RD_AT;
            state_in  = S_PULL_MV;
         end
         S_PULL_MV: begin
            cmd.wr_op = WR_SHIFT_FWD;
            if (sts.pos_last) begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_DONE;
            end else begin
               cmd.rd_op   = RD_ABOVE;
               cmd.pos_inc = 1'b1;
            end
         end
         S_DONE: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   `SAPQ_ASSERT_NEXT(a_done_holds, clock, reset, (state_ff == S_DONE) && !sts.rsp_free, state_ff == S_DONE)
   `SAPQ_ASSERT_NOW(a_idle_no_write, clock, reset, state_ff == S_IDLE, cmd.wr_op == WR_NONE)

endmodule

`default_nettype wire

// File: rtl/core/sorted_array_priority_queue.sv
// Top level: sorted-array priority queue built from a controller and a datapath.
//
//   channel | prefix | handshake         | payload
//   --------+--------+-------------------+-------------------------------------------
//   request | req_   | req_valid/stall   | opcode, item_value, item_priority
//   result  | rsp_   | rsp_valid/stall   | head_value, entry_count, error_code
//
// One item is in work at a time; the next request transfer is taken once the
// previous result sits in the output register, so it may wait there under stall.
// Peek and refused items go straight to the done state, which loads the result when free.
// Insert reads the last entry, then compares and shifts one entry back per step until its
// place is found, then writes the new item (straight away into an empty queue). Pull
// moves later entries forward one by one; with a single entry it only drops the count.
// Synchronous reset empties the queue at once; slot contents stay as they were.
`default_nettype none

module sorted_array_priority_queue
   import sapq_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   // request channel
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [1:0]                req_opcode,
   input  wire logic signed [VALUE_W-1:0] req_item_value,
   input  wire logic signed [PRIO_W-1:0]  req_item_priority,
   // result channel
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic signed [VALUE_W-1:0]      rsp_head_value,
   output logic [COUNT_W-1:0]             rsp_entry_count,
   output logic [1:0]                     rsp_error_code
);

   // Command and status bundles between the two halves
   cmd_type cmd;
   sts_type sts;

   // Sequence each operation: shift back on insert, shift forward on pull
   sapq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Hold the slots, the count and the head copy; register each result
   sapq_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_item_value    (req_item_value),
      .req_item_priority (req_item_priority),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_head_value    (rsp_head_value),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_error_code    (rsp_error_code)
   );

endmodule

`default_nettype wire

// File: test/sorted_array_priority_queue_checker.sv
// Checker: watches both channels, predicts each result and compares it field by field.
module sorted_array_priority_queue_checker
   import sapq_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire logic                      req_stall,
   input  wire logic [1:0]                req_opcode,
   input  wire logic signed [VALUE_W-1:0] req_item_value,
   input  wire logic signed [PRIO_W-1:0]  req_item_priority,
   input  wire logic                      rsp_valid,
   input  wire logic                      rsp_stall,
   input  wire logic signed [VALUE_W-1:0] rsp_head_value,
   input  wire logic [COUNT_W-1:0]        rsp_entry_count,
   input  wire logic [1:0]                rsp_error_code,
   output int                             mismatches,
   output int                             replies_outstanding,
   output int                             replies_seen,
   output int                             full_refusals,
   output int                             empty_replies,
   output int                             peak_fill
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [VALUE_W-1:0] head;
      logic [COUNT_W-1:0]        count;
      logic [1:0]                err;
   } queue_reply_type;

   logic signed [VALUE_W-1:0] held_value [DEPTH];
   logic signed [PRIO_W-1:0]  held_prio [DEPTH];
   int                        fill = 0;
   int                        fault_count = 0;
   int                        seen_count = 0;
   int                        full_count = 0;
   int                        empty_count = 0;
   int                        fill_peak = 0;
   queue_reply_type           pending_replies [$];

   // Apply one request to the shadow queue and return the reply it produces.
   function automatic queue_reply_type apply_queue_op(input logic [1:0] op,
                                                      input logic signed [VALUE_W-1:0] val,
                                                      input logic signed [PRIO_W-1:0] pri);
      queue_reply_type r;
      int              pos;
      int              k;
      r.err = ERR_OK;
      if (op == OP_INSERT) begin
         if (fill >= DEPTH) begin
            r.err = ERR_FULL;
         end else begin
            // equal priorities stay ahead of the newcomer
            pos = fill;
            while (pos > 0 && held_prio[pos-1] < pri) begin
               held_value[pos] = held_value[pos-1];
               held_prio[pos]  = held_prio[pos-1];
               pos--;
            end
            held_value[pos] = val;
            held_prio[pos]  = pri;
            fill++;
         end
      end else if (op == OP_PULL) begin
         if (fill == 0) begin
            r.err = ERR_EMPTY;
         end else begin
            for (k = 1; k < fill; k++) begin
               held_value[k-1] = held_value[k];
               held_prio[k-1]  = held_prio[k];
            end
            fill--;
         end
      end else if (fill == 0) begin
         r.err = ERR_EMPTY;
      end
      r.head  = (fill == 0) ? -32'sd1 : held_value[0];
      r.count = COUNT_W'(fill);
      return r;
   endfunction

   task automatic note_fault(input string msg);
      fault_count++;
      if (fault_count <= 10)
         $display("%0t ns: %s", $time, msg);
   endtask

   always @(posedge clock) begin
      queue_reply_type want;
      if (reset) begin
         fill = 0;
         pending_replies.delete();
      end else begin
         // the reply leaving now belongs to an earlier request
         if (rsp_valid && !rsp_stall) begin
            seen_count++;
            if (pending_replies.size() == 0) begin
               note_fault($sformatf("unexpected result: head %0d count %0d error %0d",
                                    rsp_head_value, rsp_entry_count, rsp_error_code));
            end else begin
               want = pending_replies.pop_front();
               if (rsp_head_value !== want.head)
                  note_fault($sformatf("head_value expected %0d, got %0d",
                                       want.head, rsp_head_value));
               if (rsp_entry_count !== want.count)
                  note_fault($sformatf("entry_count expected %0d, got %0d",
                                       want.count, rsp_entry_count));
               if (rsp_error_code !== want.err)
                  note_fault($sformatf("error_code expected %0d, got %0d",
                                       want.err, rsp_error_code));
            end
         end
         if (req_valid && !req_stall) begin
            want = apply_queue_op(req_opcode, req_item_value, req_item_priority);
            pending_replies.push_back(want);
            if (want.err == ERR_FULL)
               full_count++;
            if (want.err == ERR_EMPTY)
               empty_count++;
            if (fill > fill_peak)
               fill_peak = fill;
         end
      end
      mismatches          <= fault_count;
      replies_outstanding <= pending_replies.size();
      replies_seen        <= seen_count;
      full_refusals       <= full_count;
      empty_replies       <= empty_count;
      peak_fill           <= fill_peak;
   end

endmodule

// File: test/sorted_array_priority_queue_tb.sv
// Testbench top: clock, reset, request stimulus, result stall, watchdog and verdict.
module sorted_array_priority_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sapq_pkg::*;

   // opcode 3 is unused by the block and must act as a peek
   localparam logic [1:0] OP_UNUSED    = 2'd3;
   localparam int         RANDOM_ITEMS = 1200;
   localparam int         QUIET_LIMIT  = 4000;
   localparam int         DRAIN_CYCLES = 100;
   // window of transfers in which neither side idles
   localparam int         STEADY_FIRST = 500;
   localparam int         STEADY_LAST  = 700;
   localparam int         MODE_FILL    = 0;
   localparam int         MODE_DRAIN   = 1;
   localparam int         MODE_MIXED   = 2;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [1:0]                req_opcode = OP_PEEK;
   logic signed [VALUE_W-1:0] req_item_value = '0;
   logic signed [PRIO_W-1:0]  req_item_priority = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [VALUE_W-1:0] rsp_head_value;
   logic [COUNT_W-1:0]        rsp_entry_count;
   logic [1:0]                rsp_error_code;

   int   mismatches;
   int   replies_outstanding;
   int   replies_seen;
   int   full_refusals;
   int   empty_replies;
   int   peak_fill;
   int   items_sent = 0;
   int   op_tally [4] = '{0, 0, 0, 0};
   int   quiet_cycles = 0;
   logic steady = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   sorted_array_priority_queue DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_item_value    (req_item_value),
      .req_item_priority (req_item_priority),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_head_value    (rsp_head_value),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_error_code    (rsp_error_code)
   );

   sorted_array_priority_queue_checker checker_i (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_item_value      (req_item_value),
      .req_item_priority   (req_item_priority),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_head_value      (rsp_head_value),
      .rsp_entry_count     (rsp_entry_count),
      .rsp_error_code      (rsp_error_code),
      .mismatches          (mismatches),
      .replies_outstanding (replies_outstanding),
      .replies_seen        (replies_seen),
      .full_refusals       (full_refusals),
      .empty_replies       (empty_replies),
      .peak_fill           (peak_fill)
   );

   // Stall the result channel about a quarter of the time, never in the steady window.
   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(0, 99) < 26);
   end

   // Watchdog: count cycles without any transfer on either channel.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
         $display("[sorted_array_priority_queue] ERROR");
         $finish;
      end
   end

   // Offer one request after an optional random gap; hold it until the transfer.
   task automatic send_item(input logic [1:0] op,
                            input logic signed [VALUE_W-1:0] val,
                            input logic signed [PRIO_W-1:0] pri);
      while (!steady && $urandom_range(0, 99) < 26) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_opcode        <= op;
      req_item_value    <= val;
      req_item_priority <= pri;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      items_sent++;
      op_tally[op]++;
      steady <= (items_sent >= STEADY_FIRST) && (items_sent < STEADY_LAST);
   endtask

   // Mostly random values, with the extremes now and then.
   function automatic logic signed [VALUE_W-1:0] pick_value();
      if ($urandom_range(0, 9) != 0)
         return $urandom;
      case ($urandom_range(0, 3))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return -32'sd1;
         default: return 32'sd0;
      endcase
   endfunction

   // Crowd half the priorities into a narrow band so that ties are common.
   function automatic logic signed [PRIO_W-1:0] pick_priority();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 50)
         return PRIO_W'($urandom_range(0, 7) - 4);
      if (roll < 65) begin
         case ($urandom_range(0, 3))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return -16'sd1;
            default: return 16'sd0;
         endcase
      end
      return PRIO_W'($urandom);
   endfunction

   initial begin
      int          phase_left;
      int          mode;
      int unsigned roll;
      logic [1:0]  op;
      phase_left = 0;
      mode       = MODE_MIXED;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty-queue requests, unused opcode, extremes and ties.
      send_item(OP_PEEK, 32'sd0, 16'sd0);
      send_item(OP_PULL, 32'sh7FFF_FFFF, 16'sh7FFF);
      send_item(OP_UNUSED, -32'sd1, -16'sd1);
      send_item(OP_INSERT, 32'sh7FFF_FFFF, 16'sd0);
      send_item(OP_INSERT, 32'sh8000_0000, 16'sh7FFF);
      send_item(OP_INSERT, -32'sd1, 16'sh8000);
      send_item(OP_INSERT, 32'sd0, 16'sd0);
      send_item(OP_INSERT, 32'sd5, 16'sd0);
      send_item(OP_PEEK, 32'sh5A5A_5A5A, 16'sh5A5A);
      send_item(OP_UNUSED, 32'shA5A5_A5A5, 16'shA5A5);
      // drain to empty; the fifth pull must report an empty head with no error, the next one an empty error
      repeat (5) send_item(OP_PULL, 32'sd0, 16'sd0);
      send_item(OP_PULL, 32'sd0, 16'sd0);
      // a stored value of -1 at the head while the queue is not empty
      send_item(OP_INSERT, -32'sd1, 16'sh7FFF);
      send_item(OP_INSERT, 32'sh1234_5678, 16'sh7FFF);
      send_item(OP_PEEK, 32'sd0, 16'sd0);
      send_item(OP_PULL, 32'sd0, 16'sd0);
      send_item(OP_PULL, 32'sd0, 16'sd0);

      // Random: rotate fill, drain and mixed phases so the queue reaches full and empty.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (phase_left == 0) begin
            mode = (mode + 1) % 3;
            case (mode)
               MODE_FILL:  phase_left = $urandom_range(90, 160);
               MODE_DRAIN: phase_left = $urandom_range(60, 140);
               default:    phase_left = $urandom_range(20, 60);
            endcase
         end
         phase_left--;
         roll = $urandom_range(0, 99);
         case (mode)
            MODE_FILL:
               op = (roll < 75) ? OP_INSERT : (roll < 88) ? OP_PULL :
                    (roll < 97) ? OP_PEEK : OP_UNUSED;
            MODE_DRAIN:
               op = (roll < 20) ? OP_INSERT : (roll < 85) ? OP_PULL :
                    (roll < 96) ? OP_PEEK : OP_UNUSED;
            default:
               op = (roll < 42) ? OP_INSERT : (roll < 82) ? OP_PULL :
                    (roll < 95) ? OP_PEEK : OP_UNUSED;
         endcase
         send_item(op, pick_value(), pick_priority());
      end

      // Drop valid, wait out the outstanding results, then let stragglers show.
      req_valid <= 1'b0;
      @(posedge clock);
      while (replies_outstanding != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests: %0d inserts, %0d pulls, %0d peeks, %0d with opcode 3.",
               items_sent, op_tally[OP_INSERT], op_tally[OP_PULL], op_tally[OP_PEEK],
               op_tally[OP_UNUSED]);
      $display("Checked %0d results: %0d refused as full, %0d on empty, peak fill %0d of %0d.",
               replies_seen, full_refusals, empty_replies, peak_fill, DEPTH);
      if (mismatches == 0 && replies_outstanding == 0) begin
         $display("[sorted_array_priority_queue] OK");
      end else begin
         $display("%0d mismatches, %0d results never arrived", mismatches, replies_outstanding);
         $display("[sorted_array_priority_queue] ERROR");
      end
      $finish;
   end

endmodule
